// ===== rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants of the multi-timer expiry engine.
// ----------------------------------------------------------------------------
package mte_pkg;

	localparam int ACTIVE_SLOTS = 8;
	localparam int TIMER_COUNT  = 16;
	localparam int TID_W        = 4;
	localparam int SLOT_W       = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
	localparam int CNT_W        = $clog2(ACTIVE_SLOTS + 1);
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 40;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_SCAN   = 2'd2,
		ACT_ACK    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_SETUP,
		ST_SUMMARY
	} state_t;

	typedef struct packed {
		logic        fire;
		logic [31:0] rem;
	} calc_res_t;

endpackage

// ===== rtl/multi_timer_expiry_engine_core.sv =====
// ----------------------------------------------------------------------------
// multi_timer_expiry_engine_core
// Ordered active timer list with expiry scan, start, cancel and acknowledge.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser = action). Each request yields zero or more
// fire results (m_axis_tuser = 0) followed by one summary (tuser = 1, tlast).
// Scan and cancel walk the active list one slot per cycle, unless the
// receiver stalls a fire result. Start walks it twice, with a setup step
// between the walks; acknowledge goes straight to its summary. The single
// expiry/remaining-time unit is visited once per list slot. s_axis_tready
// is high only while no request is in work.
// Results leave through one output register; while the receiver stalls,
// the walk waits at the next fire or summary. cfg_we/cfg_wdata set the
// idle timeout, the next-timeout reported with no active timer.
// Reset empties the list, clears all flags and counts and sets the idle
// timeout and stored deadline to all ones.
// ----------------------------------------------------------------------------
module multi_timer_expiry_engine_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// timer_id[3:0], timeout_ticks[35:4], repeat_mode[36], now_time[68:37]
	input  logic [mte_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// action[1:0]
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// fired_id[3:0], next_timeout[35:4], event_valid[36], list_overflow[37]
	output logic [mte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// kind[0]
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import mte_pkg::*;

	state_t            state_q, state_d;
	logic [31:0]       idle_timeout_q;
	logic [31:0]       next_deadline_q;
	logic [CNT_W-1:0]  cnt_q, rd_q, wp_q;
	logic [TID_W-1:0]  list_q [ACTIVE_SLOTS];
	logic [31:0]       start_q [TIMER_COUNT];
	logic [31:0]       tl_q [TIMER_COUNT];
	logic              repeat_q [TIMER_COUNT];
	logic              cancel_q [TIMER_COUNT];
	logic [7:0]        fired_q [TIMER_COUNT];
	logic [7:0]        ignore_q [TIMER_COUNT];

	action_t           act_q;
	logic [TID_W-1:0]  tid_q;
	logic [31:0]       ticks_q, now_q, best_q;
	logic              rep_q, pass_q, found_q, ovf_q, valid_q;

	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              out_kind_q;

	logic              s_acc, can_emit, scan_more, cancelled, need_emit, keep;
	logic              scan_step, emit_sum;
	logic [TID_W-1:0]  entry_id, calc_id, in_tid;
	calc_res_t         calc;
	action_t           in_act;

	assign in_act   = action_t'(s_axis_tuser);
	assign in_tid   = s_axis_tdata[3:0];
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign can_emit = !out_valid_q || m_axis_tready;
	assign entry_id = list_q[rd_q[SLOT_W-1:0]];
	assign calc_id  = (state_q == ST_SCAN) ? entry_id : tid_q;
	assign scan_more = (rd_q < cnt_q);
	assign cancelled = cancel_q[entry_id];
	assign need_emit = !cancelled && calc.fire;
	assign keep      = !cancelled && (!calc.fire || repeat_q[entry_id]);

	mte_timer_calc u_calc (
		.now_time       (now_q),
		.start_time     (start_q[calc_id]),
		.timeout_length (tl_q[calc_id]),
		.res            (calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		scan_step     = 1'b0;
		emit_sum      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_acc) begin
					state_d = (in_act == ACT_ACK) ? ST_SUMMARY : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!scan_more) begin
					state_d = ST_SCAN_END;
				end else if (!need_emit || can_emit) begin
					scan_step = 1'b1;
				end
			end
			ST_SCAN_END: begin
				state_d = (act_q == ACT_START && !pass_q) ? ST_SETUP : ST_SUMMARY;
			end
			ST_SETUP: state_d = ST_SCAN;
			ST_SUMMARY: begin
				if (can_emit) begin
					emit_sum = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q  <= '1;
			next_deadline_q <= '1;
			cnt_q           <= '0;
			rd_q            <= '0;
			wp_q            <= '0;
			pass_q          <= 1'b0;
			found_q         <= 1'b0;
			ovf_q           <= 1'b0;
			valid_q         <= 1'b0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				repeat_q[i] <= 1'b0;
				cancel_q[i] <= 1'b0;
				fired_q[i]  <= '0;
				ignore_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				idle_timeout_q <= cfg_wdata;
			end
			if (s_acc) begin
				rd_q    <= '0;
				wp_q    <= '0;
				pass_q  <= 1'b0;
				found_q <= 1'b0;
				ovf_q   <= 1'b0;
				valid_q <= (in_act == ACT_ACK) && (ignore_q[in_tid] == 8'd0) &&
				           !cancel_q[in_tid];
				if (in_act == ACT_START || in_act == ACT_CANCEL) begin
					cancel_q[in_tid] <= 1'b1;
				end
				if (in_act == ACT_ACK) begin
					if (fired_q[in_tid] != 8'd0) begin
						fired_q[in_tid] <= fired_q[in_tid] - 8'd1;
					end
					if (ignore_q[in_tid] != 8'd0) begin
						ignore_q[in_tid] <= ignore_q[in_tid] - 8'd1;
					end
				end
			end
			if (scan_step) begin
				rd_q <= rd_q + 1'b1;
				if (pass_q && entry_id == tid_q) begin
					found_q <= 1'b1;
				end
				if (keep) begin
					wp_q <= wp_q + 1'b1;
				end
				if (need_emit) begin
					fired_q[entry_id] <= fired_q[entry_id] + 8'd1;
				end
			end
			if (state_q == ST_SCAN_END) begin
				if (pass_q && !found_q) begin
					if (wp_q >= CNT_W'(ACTIVE_SLOTS)) begin
						ovf_q <= 1'b1;
						cnt_q <= wp_q;
					end else begin
						cnt_q <= wp_q + 1'b1;
					end
					next_deadline_q <= (ticks_q < best_q && wp_q < CNT_W'(ACTIVE_SLOTS))
						? ticks_q : best_q;
				end else begin
					cnt_q           <= wp_q;
					next_deadline_q <= best_q;
				end
			end
			if (state_q == ST_SETUP) begin
				ignore_q[tid_q] <= fired_q[tid_q];
				repeat_q[tid_q] <= rep_q;
				cancel_q[tid_q] <= 1'b0;
				pass_q          <= 1'b1;
				rd_q            <= '0;
				wp_q            <= '0;
			end
			if ((scan_step && need_emit) || emit_sum) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q   <= in_act;
			tid_q   <= in_tid;
			ticks_q <= s_axis_tdata[35:4];
			rep_q   <= s_axis_tdata[36];
			now_q   <= s_axis_tdata[68:37];
			best_q  <= idle_timeout_q;
		end
		if (state_q == ST_SETUP) begin
			best_q         <= idle_timeout_q;
			start_q[tid_q] <= now_q;
			tl_q[tid_q]    <= ticks_q;
		end
		if (scan_step) begin
			if (keep) begin
				list_q[wp_q[SLOT_W-1:0]] <= entry_id;
				if (calc.rem < best_q) begin
					best_q <= calc.rem;
				end
			end
			if (need_emit && repeat_q[entry_id]) begin
				start_q[entry_id] <= now_q - 32'd1;
			end
		end
		if (state_q == ST_SCAN_END && pass_q && !found_q &&
		    wp_q < CNT_W'(ACTIVE_SLOTS)) begin
			list_q[wp_q[SLOT_W-1:0]] <= tid_q;
		end
		if (scan_step && need_emit) begin
			out_kind_q <= 1'b0;
			out_data_q <= {2'b00, 1'b0, 1'b0, 32'd0, entry_id};
		end else if (emit_sum) begin
			out_kind_q <= 1'b1;
			out_data_q <= {2'b00, ovf_q, valid_q, next_deadline_q, {TID_W{1'b0}}};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_kind_q;

endmodule

// ===== rtl/mte_timer_calc.sv =====
// ----------------------------------------------------------------------------
// mte_timer_calc
// Shared expiry check and remaining-ticks unit for one timer entry.
// ----------------------------------------------------------------------------
module mte_timer_calc (
	input  logic [31:0]       now_time,
	input  logic [31:0]       start_time,
	input  logic [31:0]       timeout_length,
	output mte_pkg::calc_res_t res
);
	import mte_pkg::*;

	logic [31:0] age;
	logic [31:0] sub;

	// a reloaded periodic timer has age 1
	always_comb begin
		age      = now_time - start_time;
		res.fire = (age >= timeout_length);
		sub      = res.fire ? 32'd1 : age;
		if (res.fire && (timeout_length == 32'd0)) begin
			res.rem = 32'd0;
		end else begin
			res.rem = timeout_length - sub;
		end
	end

endmodule

// ===== rtl/mte_checker.sv =====
// ----------------------------------------------------------------------------
// mte_port_checks
// Port-level checks of the multi-timer expiry engine, bound to the core.
// ----------------------------------------------------------------------------
module mte_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);
	import mte_pkg::*;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted a request back to back");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
		else $error("tlast does not match summary kind");

	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[39:4] == 36'd0))
		else $error("fire result carries summary fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind multi_timer_expiry_engine_core mte_port_checks u_mte_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/mte_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mte_checker
// Watches the request and result streams of the timer engine, predicts the
// fire and summary results of every accepted request from its own copy of the
// timer list, and compares them field by field in order.
// ----------------------------------------------------------------------------
module mte_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [mte_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [1:0]                      s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [mte_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            m_axis_tuser,
	input  logic                            m_axis_tlast,
	output int                              errors,
	output int                              pending
);
	import mte_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [3:0]  id;
		logic [31:0] next_to;
		logic        valid;
		logic        ovf;
		logic        last;
	} timer_res_t;

	timer_res_t  timer_results_q[$];
	logic [31:0] idle_to;
	int          act_list[$];
	logic [31:0] t_start [TIMER_COUNT];
	logic [31:0] t_len   [TIMER_COUNT];
	logic        t_rep   [TIMER_COUNT];
	logic        t_cancel[TIMER_COUNT];
	logic [7:0]  t_fired [TIMER_COUNT];
	logic [7:0]  t_ignore[TIMER_COUNT];
	logic [31:0] deadline;
	logic        ovf_seen;

	function automatic timer_res_t mk(logic kind, logic [3:0] id, logic [31:0] nt,
			logic valid, logic ovf, logic last);
		timer_res_t r;
		r.kind = kind; r.id = id; r.next_to = nt;
		r.valid = valid; r.ovf = ovf; r.last = last;
		return r;
	endfunction

	task automatic walk_list(int target, logic [31:0] now);
		logic [31:0] best;
		logic [31:0] rem;
		int          pos;
		int          id;
		best = idle_to;
		pos = 0;
		while (pos < act_list.size()) begin
			id = act_list[pos];
			if (id == target)
				target = -1;
			if (t_cancel[id]) begin
				act_list.delete(pos);
				continue;
			end
			if (now - t_start[id] >= t_len[id]) begin
				timer_results_q.push_back(mk(1'b0, id[3:0], 32'd0, 1'b0, 1'b0, 1'b0));
				t_fired[id] = t_fired[id] + 8'd1;
				if (t_rep[id])
					t_start[id] = now - 32'd1;
				else begin
					act_list.delete(pos);
					continue;
				end
			end
			if (now - t_start[id] < t_len[id])
				rem = t_start[id] + t_len[id] - now;
			else
				rem = 32'd0;
			if (rem < best)
				best = rem;
			pos++;
		end
		if (target >= 0) begin
			if (act_list.size() >= ACTIVE_SLOTS)
				ovf_seen = 1'b1;
			else begin
				rem = t_start[target] + t_len[target] - now;
				act_list.push_back(target);
				if (rem < best)
					best = rem;
			end
		end
		deadline = best;
	endtask

	task automatic predict(action_t act, logic [71:0] d);
		int          id;
		logic [31:0] now;
		logic        valid;
		id = int'(d[3:0]);
		now = d[68:37];
		valid = 1'b0;
		ovf_seen = 1'b0;
		case (act)
			ACT_SCAN: walk_list(-1, now);
			ACT_CANCEL: begin
				t_cancel[id] = 1'b1;
				walk_list(-1, now);
			end
			ACT_START: begin
				t_cancel[id] = 1'b1;
				walk_list(-1, now);
				t_ignore[id] = t_fired[id];
				t_rep[id] = d[36];
				t_cancel[id] = 1'b0;
				t_start[id] = now;
				t_len[id] = d[35:4];
				walk_list(id, now);
			end
			default: begin
				if (t_fired[id] > 0)
					t_fired[id]--;
				if (t_ignore[id] > 0)
					t_ignore[id]--;
				else if (!t_cancel[id])
					valid = 1'b1;
			end
		endcase
		timer_results_q.push_back(mk(1'b1, 4'd0, deadline, valid, ovf_seen, 1'b1));
	endtask

	task automatic check_result();
		timer_res_t e;
		if (timer_results_q.size() == 0) begin
			$error("unexpected result: data %h kind %0d", m_axis_tdata, m_axis_tuser);
			errors++;
			return;
		end
		e = timer_results_q.pop_front();
		if (m_axis_tuser !== e.kind) begin
			$error("kind: expected %0d actual %0d", e.kind, m_axis_tuser);
			errors++;
		end
		if (m_axis_tdata[3:0] !== e.id) begin
			$error("fired_id: expected %0d actual %0d", e.id, m_axis_tdata[3:0]);
			errors++;
		end
		if (m_axis_tdata[35:4] !== e.next_to) begin
			$error("next_timeout: expected %h actual %h", e.next_to, m_axis_tdata[35:4]);
			errors++;
		end
		if (m_axis_tdata[36] !== e.valid) begin
			$error("event_valid: expected %0d actual %0d", e.valid, m_axis_tdata[36]);
			errors++;
		end
		if (m_axis_tdata[37] !== e.ovf) begin
			$error("list_overflow: expected %0d actual %0d", e.ovf, m_axis_tdata[37]);
			errors++;
		end
		if (m_axis_tlast !== e.last) begin
			$error("last: expected %0d actual %0d", e.last, m_axis_tlast);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_to = '1;
			deadline = '1;
			act_list.delete();
			timer_results_q.delete();
			for (int i = 0; i < TIMER_COUNT; i++) begin
				t_start[i] = '0;
				t_len[i] = '0;
				t_rep[i] = 1'b0;
				t_cancel[i] = 1'b0;
				t_fired[i] = '0;
				t_ignore[i] = '0;
			end
		end else begin
			if (cfg_we)
				idle_to = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				predict(action_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
		end
		pending = timer_results_q.size();
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, cancel, scan and acknowledge requests into the timer engine
// through directed and random phases with varied idling and stalls, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
	import mte_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [31:0]           cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [1:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	int                    errors;
	int                    pending;
	int                    idle_pct;
	int                    stall_pct;
	int                    hold_req;
	int                    hold_left;
	int                    cycles;
	logic [31:0]           tnow;

	multi_timer_expiry_engine_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	mte_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(action_t act, logic [3:0] id, logic [31:0] ticks, logic rep,
			logic [31:0] now);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {3'b0, now, rep, ticks, id};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_idle(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request();
		int          r;
		logic [31:0] ticks;
		r = $urandom_range(99);
		if ($urandom_range(19) == 0)
			tnow = $urandom;
		else
			tnow = tnow + $urandom_range(0, 24);
		ticks = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 60);
		if (r < 38)
			send(ACT_START, 4'($urandom_range(15)), ticks, 1'($urandom_range(1)), tnow);
		else if (r < 72)
			send(ACT_SCAN, 4'($urandom_range(15)), $urandom, 1'($urandom_range(1)), tnow);
		else if (r < 86)
			send(ACT_CANCEL, 4'($urandom_range(15)), $urandom, 1'($urandom_range(1)), tnow);
		else
			send(ACT_ACK, 4'($urandom_range(15)), $urandom, 1'($urandom_range(1)), tnow);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_SCAN;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		tnow = 32'd100;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'd0);
		send(ACT_ACK, 4'd15, '0, 1'b0, 32'd0);
		send(ACT_START, 4'd0, 32'd0, 1'b0, 32'd5);
		send(ACT_START, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'd6);
		send(ACT_ACK, 4'd0, '0, 1'b0, 32'd6);
		send(ACT_ACK, 4'd0, '0, 1'b0, 32'd6);
		send(ACT_START, 4'd3, 32'd4, 1'b1, 32'd10);
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'd20);
		send(ACT_START, 4'd3, 32'd2, 1'b0, 32'd21);
		send(ACT_CANCEL, 4'd15, '0, 1'b0, 32'd22);
		send(ACT_ACK, 4'd15, '0, 1'b0, 32'd22);
		for (int i = 1; i <= 9; i++)
			send(ACT_START, i[3:0] + 4'd4, 32'd1000 + i, i[0], 32'd30);
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'd5000);
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'h8000_0000);
		drain();
		write_idle(32'd0);
		send(ACT_SCAN, 4'd0, '0, 1'b0, 32'd1);
		drain();
		write_idle(32'h0000_1234);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 88; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 88; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			for (int n = 0; n < 70; n++) begin
				if (ph == 0 && n == 20)
					hold_req = 400;
				random_request();
			end
			drain();
			case (ph)
				0: write_idle(32'hFFFF_FFFF);
				1: write_idle($urandom);
				2: write_idle(32'd50);
				default: write_idle(32'hFFFF_FFFF);
			endcase
		end
		drain();
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
